FILE: rtl/rotation_matrix_to_rpy_macros.svh
// assertion macros for the rotation matrix to roll/pitch/yaw converter
// used by the port checker; expects clk and rst_n in scope
`ifndef ROTATION_MATRIX_TO_RPY_MACROS_SVH
`define ROTATION_MATRIX_TO_RPY_MACROS_SVH

// same-cycle implication, idle during reset
`define RMRPY_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmrpy check failed");

// next-cycle implication, idle during reset
`define RMRPY_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmrpy check failed");

`endif

FILE: rtl/rmrpy_pkg.sv
// shared types, widths and constants of the rotation matrix to rpy converter
// no dependencies
`default_nettype none

package rmrpy_pkg;

    localparam int CORDIC_STAGES = 14;
    localparam int MW       = 16;              // matrix entry width
    localparam int AW       = 16;              // output angle width
    localparam int THR_W    = 11;              // threshold register width
    localparam int OPW      = 34;              // atan2 operand width
    localparam int CW       = 34;              // cordic x/y width
    localparam int ZW       = 25;              // cordic angle width, scale 2^20
    localparam int SQ_STEPS = 8;               // isqrt stages, two root bits each
    localparam int TOP_ST   = 2 + SQ_STEPS;    // stages ahead of the atan2 lanes
    localparam int LANE_ST  = CORDIC_STAGES + 5;
    localparam int NST      = TOP_ST + LANE_ST;

    localparam logic signed [ZW-1:0] ANG_PI  = 25'sd3294199;
    localparam logic signed [AW-1:0] OUT_MAX = 16'sd25736;

    // configuration register indexes
    localparam logic REG_ANGLE_ORDER = 1'b0;
    localparam logic REG_ZERO_THR    = 1'b1;

    // angle order codes
    localparam logic ORDER_XYZ = 1'b0;
    localparam logic ORDER_ZYX = 1'b1;

    typedef struct packed {
        logic signed [MW-1:0] m00;
        logic signed [MW-1:0] m01;
        logic signed [MW-1:0] m02;
        logic signed [MW-1:0] m10;
        logic signed [MW-1:0] m11;
        logic signed [MW-1:0] m12;
        logic signed [MW-1:0] m20;
        logic signed [MW-1:0] m22;
    } mat_t;

    typedef struct packed {
        logic signed [AW-1:0] angle_first;
        logic signed [AW-1:0] angle_second;
        logic signed [AW-1:0] angle_third;
        logic                 singular;
    } rpy_t;

    // atan(2^-i) at scale 2^20, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_step(input int i);
        logic signed [ZW-1:0] r;
        case (i)
            0:       r = 25'sd823550;
            1:       r = 25'sd486170;
            2:       r = 25'sd256879;
            3:       r = 25'sd130396;
            4:       r = 25'sd65451;
            5:       r = 25'sd32757;
            6:       r = 25'sd16383;
            7:       r = 25'sd8192;
            8:       r = 25'sd4096;
            9:       r = 25'sd2048;
            10:      r = 25'sd1024;
            11:      r = 25'sd512;
            12:      r = 25'sd256;
            13:      r = 25'sd128;
            14:      r = 25'sd64;
            15:      r = 25'sd32;
            16:      r = 25'sd16;
            17:      r = 25'sd8;
            18:      r = 25'sd4;
            19:      r = 25'sd2;
            20:      r = 25'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rmrpy_atan2.sv
// pipelined atan2 lane: normalize, pre-rotate, vectoring cordic, round
// depends on rmrpy_pkg
`default_nettype none

module rmrpy_atan2
    import rmrpy_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic [LANE_ST-1:0]     stage_en,
    input  wire logic signed [OPW-1:0]  y,
    input  wire logic signed [OPW-1:0]  x,
    output logic signed [AW-1:0]        angle
);

    localparam logic signed [ZW-1:0] SAT_HI = ZW'(OUT_MAX);
    localparam logic signed [ZW-1:0] SAT_LO = -SAT_HI;

    // magnitude stage
    logic signed [OPW-1:0] ax_y_reg, ax_x_reg;
    logic [OPW-1:0]        ax_m_reg;
    logic [OPW-1:0]        abs_x, abs_y;

    always_comb
    begin
        abs_x = x[OPW-1] ? $unsigned(-x) : $unsigned(x);
        abs_y = y[OPW-1] ? $unsigned(-y) : $unsigned(y);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            ax_y_reg <= y;
            ax_x_reg <= x;
            ax_m_reg <= (abs_x > abs_y) ? abs_x : abs_y;
        end
    end

    // leading one search on the larger magnitude
    logic signed [OPW-1:0] lz_y_reg, lz_x_reg;
    logic                  lz_shr_reg, lz_zero_reg;
    logic [4:0]            lz_k_reg;
    logic [4:0]            msb_pos;

    always_comb
    begin
        msb_pos = '0;
        for (int i = 0; i < 31; i++)
        begin
            if (ax_m_reg[i])
                msb_pos = 5'(i);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            lz_y_reg    <= ax_y_reg;
            lz_x_reg    <= ax_x_reg;
            lz_shr_reg  <= |ax_m_reg[OPW-1:31];
            lz_k_reg    <= 5'd30 - msb_pos;
            lz_zero_reg <= (ax_m_reg == '0);
        end
    end

    // normalize so the larger magnitude sits in [2^30, 2^31)
    logic signed [CW-1:0] nm_y_reg, nm_x_reg;
    logic                 nm_zero_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            nm_y_reg    <= lz_shr_reg ? (lz_y_reg >>> 1) : (lz_y_reg <<< lz_k_reg);
            nm_x_reg    <= lz_shr_reg ? (lz_x_reg >>> 1) : (lz_x_reg <<< lz_k_reg);
            nm_zero_reg <= lz_zero_reg;
        end
    end

    // cordic pipeline, entry 0 is the pre-rotated vector
    logic signed [CW-1:0] cx_reg [0:CORDIC_STAGES];
    logic signed [CW-1:0] cy_reg [0:CORDIC_STAGES];
    logic signed [ZW-1:0] cz_reg [0:CORDIC_STAGES];
    logic                 cf_reg [0:CORDIC_STAGES];

    // left half plane moves over by plus or minus pi
    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            cf_reg[0] <= nm_zero_reg;
            if (nm_x_reg < 0)
            begin
                cx_reg[0] <= -nm_x_reg;
                cy_reg[0] <= -nm_y_reg;
                cz_reg[0] <= (nm_y_reg >= 0) ? ANG_PI : -ANG_PI;
            end
            else
            begin
                cx_reg[0] <= nm_x_reg;
                cy_reg[0] <= nm_y_reg;
                cz_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        always_ff @(posedge clk)
        begin
            if (stage_en[4+i])
            begin
                cf_reg[i+1] <= cf_reg[i];
                if (cy_reg[i] >= 0)
                begin
                    cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] + atan_step(i);
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] - atan_step(i);
                end
            end
        end
    end

    // round half away from zero to Q2.13 and saturate
    logic signed [ZW-1:0] z_fin, q_rnd, q_sat;

    always_comb
    begin
        z_fin = cz_reg[CORDIC_STAGES];
        if (z_fin >= 0)
            q_rnd = (z_fin + 25'sd64) >>> 7;
        else
            q_rnd = -((-z_fin + 25'sd64) >>> 7);
        if (q_rnd > SAT_HI)
            q_sat = SAT_HI;
        else if (q_rnd < SAT_LO)
            q_sat = SAT_LO;
        else
            q_sat = q_rnd;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[4+CORDIC_STAGES])
            angle <= cf_reg[CORDIC_STAGES] ? '0 : q_sat[AW-1:0];
    end

endmodule

`default_nettype wire

FILE: rtl/rotation_matrix_to_rpy.sv
// rotation matrix to roll/pitch/yaw: 29 register stages, one beat accepted per cycle while src_stall is low.
// depth set by the 8-stage isqrt (two root bits a stage) and 14 cordic stages per lane;
// a stall holds only the stages that are full, empty stages keep filling.
// rst_n clears all valid bits; angle_order resets to zyx, zero_threshold to 1.
`default_nettype none

module rotation_matrix_to_rpy
    import rmrpy_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              src_valid,
    output logic                   src_stall,
    input  wire mat_t              src_data,
    output logic                   dst_valid,
    input  wire logic              dst_stall,
    output rpy_t                   dst_data,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [THR_W-1:0]  cfg_data
);

    typedef struct packed {
        logic               sing;
        logic signed [16:0] y0;
        logic signed [16:0] x0;
        logic signed [16:0] y1;
        logic signed [16:0] x1s;
        logic signed [33:0] y2;
        logic signed [33:0] x2;
        logic [31:0]        rad;
        logic [17:0]        rem;
        logic [15:0]        root;
    } sq_t;

    function automatic logic signed [16:0] ext17(input logic signed [MW-1:0] v);
        return $signed({v[MW-1], v});
    endfunction

    function automatic logic signed [16:0] neg17(input logic signed [MW-1:0] v);
        return -$signed({v[MW-1], v});
    endfunction

    function automatic logic [16:0] abs17(input logic signed [MW-1:0] v);
        logic [16:0] a;
        a = {v[MW-1], v};
        return v[MW-1] ? (~a + 17'd1) : a;
    endfunction

    // configuration registers
    logic             order_reg;
    logic [THR_W-1:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= ORDER_ZYX;
            thr_reg   <= THR_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ANGLE_ORDER: order_reg <= cfg_data[0];
                REG_ZERO_THR:    thr_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // stage valids and enables, a stage moves when empty or when its successor moves
    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;

    assign en[NST-1] = !v_reg[NST-1] || !dst_stall;
    for (genvar i = 0; i < NST-1; i++)
    begin : g_en
        assign en[i] = !v_reg[i] || en[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= src_valid;
            for (int i = 1; i < NST; i++)
            begin
                if (en[i])
                    v_reg[i] <= v_reg[i-1];
            end
        end
    end

    assign src_stall = !en[0];
    assign dst_valid = v_reg[NST-1];

    // singular test and operand selection
    logic               xyz, sing_c;
    logic signed [MW-1:0] t_a, t_b;
    logic signed [16:0] y0_c, x0_c, y1_c, x1s_c;
    logic signed [16:0] pa_a, pa_b, pb_a, pb_b, pc_a, pc_b, pd_a, pd_b;
    logic signed [31:0] sqa_c, sqb_c;
    logic signed [33:0] pa_c, pb_c, pc_c, pd_c;

    always_comb
    begin
        xyz    = (order_reg == ORDER_XYZ);
        t_a    = xyz ? src_data.m22 : src_data.m00;
        t_b    = xyz ? src_data.m12 : src_data.m10;
        sing_c = (abs17(t_a) < {6'd0, thr_reg}) && (abs17(t_b) < {6'd0, thr_reg});

        // first angle
        if (sing_c)
        begin
            y0_c = '0;
            x0_c = '0;
        end
        else if (xyz)
        begin
            y0_c = neg17(src_data.m12);
            x0_c = ext17(src_data.m22);
        end
        else
        begin
            y0_c = ext17(src_data.m10);
            x0_c = ext17(src_data.m00);
        end

        // second angle, x replaced by the root when not singular
        y1_c  = xyz ? ext17(src_data.m02) : neg17(src_data.m20);
        x1s_c = xyz ? ext17(src_data.m22) : ext17(src_data.m00);

        // third angle as a difference of products
        pb_a = '0;
        pb_b = '0;
        pd_a = '0;
        pd_b = '0;
        pa_b = 17'sd1;
        pc_b = 17'sd1;
        if (!xyz && !sing_c)
        begin
            pa_a = ext17(src_data.m10);
            pa_b = ext17(src_data.m02);
            pb_a = ext17(src_data.m00);
            pb_b = ext17(src_data.m12);
            pc_a = ext17(src_data.m00);
            pc_b = ext17(src_data.m11);
            pd_a = ext17(src_data.m10);
            pd_b = ext17(src_data.m01);
        end
        else if (!xyz)
        begin
            pa_a = neg17(src_data.m12);
            pc_a = ext17(src_data.m11);
        end
        else if (sing_c)
        begin
            pa_a = ext17(src_data.m10);
            pc_a = ext17(src_data.m11);
        end
        else
        begin
            pa_a = neg17(src_data.m01);
            pc_a = ext17(src_data.m00);
        end

        sqa_c = t_a * t_a;
        sqb_c = t_b * t_b;
        pa_c  = pa_a * pa_b;
        pb_c  = pb_a * pb_b;
        pc_c  = pc_a * pc_b;
        pd_c  = pd_a * pd_b;
    end

    // product stage
    logic               s0_sing_reg;
    logic signed [16:0] s0_y0_reg, s0_x0_reg, s0_y1_reg, s0_x1s_reg;
    logic [31:0]        s0_sqa_reg, s0_sqb_reg;
    logic signed [33:0] s0_pa_reg, s0_pb_reg, s0_pc_reg, s0_pd_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_sing_reg <= sing_c;
            s0_y0_reg   <= y0_c;
            s0_x0_reg   <= x0_c;
            s0_y1_reg   <= y1_c;
            s0_x1s_reg  <= x1s_c;
            s0_sqa_reg  <= $unsigned(sqa_c);
            s0_sqb_reg  <= $unsigned(sqb_c);
            s0_pa_reg   <= pa_c;
            s0_pb_reg   <= pb_c;
            s0_pc_reg   <= pc_c;
            s0_pd_reg   <= pd_c;
        end
    end

    // sum stage, entry 0 of the isqrt chain
    sq_t sq_reg [0:SQ_STEPS];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            sq_reg[0].sing <= s0_sing_reg;
            sq_reg[0].y0   <= s0_y0_reg;
            sq_reg[0].x0   <= s0_x0_reg;
            sq_reg[0].y1   <= s0_y1_reg;
            sq_reg[0].x1s  <= s0_x1s_reg;
            sq_reg[0].y2   <= s0_pa_reg - s0_pb_reg;
            sq_reg[0].x2   <= s0_pc_reg - s0_pd_reg;
            sq_reg[0].rad  <= s0_sqa_reg + s0_sqb_reg;
            sq_reg[0].rem  <= '0;
            sq_reg[0].root <= '0;
        end
    end

    // integer square root, two root bits per stage
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_isqrt
        sq_t        sq_next;
        logic [19:0] trial, part;

        always_comb
        begin
            sq_next = sq_reg[k];
            for (int s = 0; s < 2; s++)
            begin
                part  = {sq_next.rem, sq_next.rad[31:30]};
                trial = {2'b00, sq_next.root, 2'b01};
                sq_next.rad = {sq_next.rad[29:0], 2'b00};
                if (part >= trial)
                begin
                    sq_next.rem  = 18'(part - trial);
                    sq_next.root = {sq_next.root[14:0], 1'b1};
                end
                else
                begin
                    sq_next.rem  = part[17:0];
                    sq_next.root = {sq_next.root[14:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[2+k])
                sq_reg[k+1] <= sq_next;
        end
    end

    // lane operands
    sq_t                  sq_end;
    logic signed [OPW-1:0] ly0, lx0, ly1, lx1, ly2, lx2;

    always_comb
    begin
        sq_end = sq_reg[SQ_STEPS];
        ly0 = {{(OPW-17){sq_end.y0[16]}}, sq_end.y0};
        lx0 = {{(OPW-17){sq_end.x0[16]}}, sq_end.x0};
        ly1 = {{(OPW-17){sq_end.y1[16]}}, sq_end.y1};
        lx1 = sq_end.sing ? {{(OPW-17){sq_end.x1s[16]}}, sq_end.x1s}
                          : {{(OPW-16){1'b0}}, sq_end.root};
        ly2 = sq_end.y2;
        lx2 = sq_end.x2;
    end

    rmrpy_atan2 u_lane0 (
        .clk      (clk),
        .stage_en (en[NST-1:TOP_ST]),
        .y        (ly0),
        .x        (lx0),
        .angle    (dst_data.angle_first)
    );

    rmrpy_atan2 u_lane1 (
        .clk      (clk),
        .stage_en (en[NST-1:TOP_ST]),
        .y        (ly1),
        .x        (lx1),
        .angle    (dst_data.angle_second)
    );

    rmrpy_atan2 u_lane2 (
        .clk      (clk),
        .stage_en (en[NST-1:TOP_ST]),
        .y        (ly2),
        .x        (lx2),
        .angle    (dst_data.angle_third)
    );

    // singular flag follows the lanes
    logic sg_reg [0:LANE_ST-1];

    always_ff @(posedge clk)
    begin
        if (en[TOP_ST])
            sg_reg[0] <= sq_end.sing;
        for (int j = 1; j < LANE_ST; j++)
        begin
            if (en[TOP_ST+j])
                sg_reg[j] <= sg_reg[j-1];
        end
    end

    assign dst_data.singular = sg_reg[LANE_ST-1];

endmodule

`default_nettype wire

FILE: rtl/rmrpy_checker.sv
// port checker for the rotation matrix to rpy converter, bound to the top level
// depends on rmrpy_pkg and rotation_matrix_to_rpy_macros.svh
`default_nettype none
`include "rotation_matrix_to_rpy_macros.svh"

module rmrpy_checker
    import rmrpy_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic dst_valid,
    input wire logic dst_stall,
    input wire rpy_t dst_data
);

    // a stalled output beat stays put
    `RMRPY_AST_NXT(a_valid_hold, dst_valid && dst_stall, dst_valid)
    `RMRPY_AST_NXT(a_data_hold, dst_valid && dst_stall, $stable(dst_data))

    // singular beats carry a zero first angle
    `RMRPY_AST_IMP(a_sing_zero, dst_valid && dst_data.singular, dst_data.angle_first == '0)

    // angles stay inside the saturation range
    `RMRPY_AST_IMP(a_range, dst_valid, (dst_data.angle_first <= OUT_MAX) && (dst_data.angle_first >= -OUT_MAX) && (dst_data.angle_second <= OUT_MAX) && (dst_data.angle_second >= -OUT_MAX) && (dst_data.angle_third <= OUT_MAX) && (dst_data.angle_third >= -OUT_MAX))

endmodule

bind rotation_matrix_to_rpy rmrpy_checker u_rmrpy_checker (.*);

`default_nettype wire

FILE: verif/tb_top.sv
// self-checking testbench for the rotation matrix to roll/pitch/yaw converter
// drives matrices with random gaps and output stalls and checks each result beat
// depends on rmrpy_pkg and rotation_matrix_to_rpy
`default_nettype none

module tb_top;
    import rmrpy_pkg::*;

    // angle arithmetic mirrors the converter: q20 cordic, q2.13 output
    localparam longint HALF_TURN  = 3294199;
    localparam longint ANGLE_SAT  = 25736;
    localparam int     DRAIN_WAIT = 80;
    localparam int     IDLE_LIMIT = 4000;

    class rpy_scoreboard;
        rpy_t   pending[$];
        bit     order_zyx;
        longint threshold;
        int     mismatches;
        int     checked;
        int     singular_seen;

        function new();
            order_zyx  = 1'b1;
            threshold  = 1;
            mismatches = 0;
            checked    = 0;
            singular_seen = 0;
        endfunction

        function longint shr(longint v, int s);
            return v >>> s;
        endfunction

        function longint mag(longint v);
            return v < 0 ? -v : v;
        endfunction

        function longint cordic_atan2(longint y, longint x);
            longint m;
            longint z;
            longint xn;
            longint q;
            longint step;
            m = mag(x) > mag(y) ? mag(x) : mag(y);
            z = 0;
            if (m == 0)
                return 0;
            while (m < (64'sd1 << 30))
            begin
                x = x * 2;
                y = y * 2;
                m = m * 2;
            end
            while (m >= (64'sd1 << 31))
            begin
                x = shr(x, 1);
                y = shr(y, 1);
                m = m >>> 1;
            end
            if (x < 0)
            begin
                z = (y >= 0) ? HALF_TURN : -HALF_TURN;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < CORDIC_STAGES; i++)
            begin
                step = atan_table(i);
                if (y >= 0)
                begin
                    xn = x + shr(y, i);
                    y  = y - shr(x, i);
                    z  = z + step;
                end
                else
                begin
                    xn = x - shr(y, i);
                    y  = y + shr(x, i);
                    z  = z - step;
                end
                x = xn;
            end
            q = (z >= 0) ? ((z + 64) >>> 7) : -((-z + 64) >>> 7);
            if (q > ANGLE_SAT)
                q = ANGLE_SAT;
            if (q < -ANGLE_SAT)
                q = -ANGLE_SAT;
            return q;
        endfunction

        function longint atan_table(int i);
            longint t[14] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
                              8192, 4096, 2048, 1024, 512, 256, 128};
            return t[i];
        endfunction

        function longint root_floor(longint v);
            longint r;
            r = longint'($sqrt(real'(v)));
            while (r * r > v)
                r--;
            while ((r + 1) * (r + 1) <= v)
                r++;
            return r;
        endfunction

        // note an accepted matrix and queue its expected angles
        function void note_matrix(mat_t mt);
            longint a00, a01, a02, a10, a11, a12, a20, a22;
            rpy_t   e;
            a00 = mt.m00; a01 = mt.m01; a02 = mt.m02; a10 = mt.m10;
            a11 = mt.m11; a12 = mt.m12; a20 = mt.m20; a22 = mt.m22;
            if (order_zyx == ORDER_XYZ)
            begin
                e.singular = mag(a22) < threshold && mag(a12) < threshold;
                if (e.singular)
                begin
                    e.angle_first  = '0;
                    e.angle_second = AW'(cordic_atan2(a02, a22));
                    e.angle_third  = AW'(cordic_atan2(a10, a11));
                end
                else
                begin
                    e.angle_first  = AW'(cordic_atan2(-a12, a22));
                    e.angle_second = AW'(cordic_atan2(a02,
                                         root_floor(a12 * a12 + a22 * a22)));
                    e.angle_third  = AW'(cordic_atan2(-a01, a00));
                end
            end
            else
            begin
                e.singular = mag(a00) < threshold && mag(a10) < threshold;
                if (e.singular)
                begin
                    e.angle_first  = '0;
                    e.angle_second = AW'(cordic_atan2(-a20, a00));
                    e.angle_third  = AW'(cordic_atan2(-a12, a11));
                end
                else
                begin
                    e.angle_first  = AW'(cordic_atan2(a10, a00));
                    e.angle_second = AW'(cordic_atan2(-a20,
                                         root_floor(a00 * a00 + a10 * a10)));
                    e.angle_third  = AW'(cordic_atan2(a10 * a02 - a00 * a12,
                                                      a00 * a11 - a10 * a01));
                end
            end
            pending.push_back(e);
        endfunction

        // compare a result beat with the oldest expectation
        function void check_angles(rpy_t got);
            rpy_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", got);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.singular)
                singular_seen++;
            if (got.angle_first !== e.angle_first || got.angle_second !== e.angle_second
                || got.angle_third !== e.angle_third || got.singular !== e.singular)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch beat %0d: exp %0d %0d %0d s%0b got %0d %0d %0d s%0b",
                             checked, e.angle_first, e.angle_second, e.angle_third,
                             e.singular, got.angle_first, got.angle_second,
                             got.angle_third, got.singular);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        src_valid;
    logic        src_stall;
    mat_t        src_data;
    logic        dst_valid;
    logic        dst_stall;
    rpy_t        dst_data;
    logic        cfg_we;
    logic        cfg_index;
    logic [THR_W-1:0] cfg_data;

    rpy_scoreboard sb;
    int  idle_cycles;
    bit  stimulus_done;
    int  sent;

    rotation_matrix_to_rpy dut (
        .clk(clk), .rst_n(rst_n),
        .src_valid(src_valid), .src_stall(src_stall), .src_data(src_data),
        .dst_valid(dst_valid), .dst_stall(dst_stall), .dst_data(dst_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // sample accepted beats at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (src_valid && !src_stall)
                sb.note_matrix(src_data);
            if (dst_valid && !dst_stall)
                sb.check_angles(dst_data);
        end
    end

    // watchdog on cycles with no accepted beat
    always @(posedge clk)
    begin
        if ((src_valid && !src_stall) || (dst_valid && !dst_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // random output stalls, with calm stretches
    always @(negedge clk)
    begin
        int gap;
        if (!rst_n || stimulus_done)
            dst_stall <= 1'b0;
        else if (dst_valid && dst_stall === 1'b0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            if (sent % 200 > 150)
                gap = 0;
            dst_stall <= (gap != 0) && ($urandom_range(0, 4) < gap);
        end
        else
            dst_stall <= ($urandom_range(0, 3) == 0) && (sent % 200 <= 150);
    end

    task automatic write_reg(logic idx, logic [THR_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_ANGLE_ORDER)
            sb.order_zyx = val[0];
        else
            sb.threshold = val;
    endtask

    // send one matrix beat, after a random gap unless no_gap is set; valid stays up for a beat that follows
    task automatic send_matrix(mat_t mt, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= mt;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic wait_drained();
        src_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    function automatic logic signed [MW-1:0] rand_entry(int thr);
        case ($urandom_range(0, 5))
            0: return MW'($urandom_range(0, thr + 2) * ($urandom_range(0, 1) ? 1 : -1));
            1: return MW'($urandom());
            2: return ($urandom_range(0, 1)) ? 16'sd16384 : -16'sd16384;
            default: return MW'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // a proper rotation from three random angles
    function automatic mat_t rand_rotation();
        real a, b, c;
        mat_t mt;
        a = ($urandom_range(0, 62831) / 10000.0) - 3.14159;
        b = ($urandom_range(0, 62831) / 10000.0) - 3.14159;
        c = ($urandom_range(0, 62831) / 10000.0) - 3.14159;
        if ($urandom_range(0, 5) == 0)
            b = ($urandom_range(0, 1) ? 1.5707963 : -1.5707963);
        mt.m00 = MW'($rtoi(16384.0 * $cos(a) * $cos(b)));
        mt.m01 = MW'($rtoi(16384.0 * ($cos(a) * $sin(b) * $sin(c) - $sin(a) * $cos(c))));
        mt.m02 = MW'($rtoi(16384.0 * ($cos(a) * $sin(b) * $cos(c) + $sin(a) * $sin(c))));
        mt.m10 = MW'($rtoi(16384.0 * $sin(a) * $cos(b)));
        mt.m11 = MW'($rtoi(16384.0 * ($sin(a) * $sin(b) * $sin(c) + $cos(a) * $cos(c))));
        mt.m12 = MW'($rtoi(16384.0 * ($sin(a) * $sin(b) * $cos(c) - $cos(a) * $sin(c))));
        mt.m20 = MW'($rtoi(-16384.0 * $sin(b)));
        mt.m22 = MW'($rtoi(16384.0 * $cos(b) * $cos(c)));
        return mt;
    endfunction

    function automatic mat_t rand_matrix(int thr);
        mat_t mt;
        if ($urandom_range(0, 3) != 0)
            mt = rand_rotation();
        else
        begin
            mt.m00 = rand_entry(thr); mt.m01 = rand_entry(thr);
            mt.m02 = rand_entry(thr); mt.m10 = rand_entry(thr);
            mt.m11 = rand_entry(thr); mt.m12 = rand_entry(thr);
            mt.m20 = rand_entry(thr); mt.m22 = rand_entry(thr);
        end
        // force the singular pair small now and then
        if ($urandom_range(0, 7) == 0)
        begin
            mt.m00 = MW'($signed($urandom_range(0, 2 * thr)) - thr);
            mt.m10 = MW'($signed($urandom_range(0, 2 * thr)) - thr);
            mt.m12 = MW'($signed($urandom_range(0, 2 * thr)) - thr);
            mt.m22 = MW'($signed($urandom_range(0, 2 * thr)) - thr);
        end
        return mt;
    endfunction

    // directed matrices for one order setting
    task automatic directed_set();
        mat_t mt;
        mt = '0;
        send_matrix(mt, 1'b0);                               // all zero
        mt = {8{16'sd16384}};
        send_matrix(mt, 1'b1);
        mt = {8{-16'sd16384}};
        send_matrix(mt, 1'b0);
        mt = {8{16'h7fff}};
        send_matrix(mt, 1'b1);
        mt = {8{16'h8000}};
        send_matrix(mt, 1'b0);
        mt = '{16384, 0, 0, 0, 16384, 0, 0, 16384};         // identity
        send_matrix(mt, 1'b1);
        mt = '{-16384, 0, 0, 0, -16384, 0, 0, 16384};       // half turn, negative x
        send_matrix(mt, 1'b0);
        mt = '{-16384, 0, 0, 1, -16384, -1, 0, -16384};     // negative x, y positive or zero
        send_matrix(mt, 1'b0);
        mt = '{0, 0, 16384, 0, 16384, 0, -16384, 0};        // gimbal lock
        send_matrix(mt, 1'b1);
        mt = '{0, 0, -16384, 0, 16384, 0, 16384, 0};
        send_matrix(mt, 1'b0);
    endtask

    initial
    begin
        mat_t mt;
        int   thr;
        sb = new();
        rst_n     = 1'b0;
        src_valid = 1'b0;
        src_data  = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_ANGLE_ORDER;
        cfg_data  = '0;
        dst_stall = 1'b0;
        stimulus_done = 1'b0;
        sent = 0;
        idle_cycles = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part under reset settings, then xyz
        directed_set();
        wait_drained();
        write_reg(REG_ANGLE_ORDER, THR_W'(ORDER_XYZ));
        directed_set();
        wait_drained();

        // random phases sweeping order and threshold
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: thr = 0;
                1: thr = 1024;
                2: thr = 1;
                3: thr = 2047;
                default: thr = $urandom_range(0, 1024);
            endcase
            write_reg(REG_ZERO_THR, THR_W'(thr));
            write_reg(REG_ANGLE_ORDER, THR_W'(ph[0]));
            for (int k = 0; k < 75; k++)
            begin
                mt = rand_matrix(thr == 0 ? 4 : thr);
                send_matrix(mt, ($urandom_range(0, 2) == 0));
                if (k == 40 && ph == 2)
                    wait_drained();
            end
            wait_drained();
        end
        stimulus_done = 1'b1;
        wait_drained();

        $display("sent %0d matrices over both angle orders and thresholds 0 to 2047",
                 sent);
        $display("checked %0d results, %0d on the singular branch",
                 sb.checked, sb.singular_seen);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/rmrpy_pkg.sv
rtl/rmrpy_atan2.sv
rtl/rotation_matrix_to_rpy.sv
rtl/rmrpy_checker.sv
verif/tb_top.sv
